@@ design/buddy_page_allocator_core_defines.svh @@
// assertion macros for the buddy page allocator checker
// no dependencies; taken in by the checker file only
`ifndef BUDDY_PAGE_ALLOCATOR_CORE_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, quiet while reset is asserted
`define BPA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet while reset is asserted
`define BPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/bpa_pkg.sv @@
// shared types and codes for the buddy page allocator
// no dependencies; used by controller, datapath, top level and checker
package bpa_pkg;

	localparam int REQ_W  = 11;
	localparam int NEED_W = 12;
	localparam int PAGE_W = 20;
	localparam int LF_W   = 11;

	typedef logic [REQ_W-1:0]  req_t;
	typedef logic [NEED_W-1:0] need_t;
	typedef logic [PAGE_W-1:0] page_t;
	typedef logic [LF_W-1:0]   lf_t;
	typedef logic [1:0]        st_t;

	// operation codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// result status codes
	localparam st_t ST_OK            = 2'd0;
	localparam st_t ST_NO_SPACE      = 2'd1;
	localparam st_t ST_NOT_ALLOCATED = 2'd2;

	// input word
	typedef struct packed {
		logic  op;
		req_t  request_pages;
		page_t free_page;
	} bpa_in_t;

	// result word
	typedef struct packed {
		st_t   status;
		page_t alloc_page;
		lf_t   largest_free;
	} bpa_out_t;

	// datapath actions
	typedef enum logic [3:0] {
		DP_NOP     = 4'd0,
		DP_LOAD    = 4'd1,
		DP_CLR     = 4'd2,
		DP_DINIT   = 4'd3,
		DP_DSTEP   = 4'd4,
		DP_MARK    = 4'd5,
		DP_LINIT   = 4'd6,
		DP_CLIMB   = 4'd7,
		DP_RESTORE = 4'd8,
		DP_MERGE   = 4'd9
	} dp_op_t;

	// controller to datapath
	typedef struct packed {
		dp_op_t op;
		logic   st_we;
		st_t    st_code;
	} bpa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic op_free;
		logic no_space;
		logic root_gt_need;
		logic half_gt_need;
		logic out_range;
		logic at_root;
		logic parent_root;
		logic node_used;
	} bpa_sts_t;

endpackage

@@ design/buddy_page_allocator_core.sv @@
// top level of the buddy page allocator: controller plus datapath
// depends on bpa_pkg, bpa_ctrl and bpa_dpath
//
// channel  dir  handshake              word
// item     in   start, busy            bpa_in_t: op, request_pages, free_page
// result   out  done (one-cycle)       bpa_out_t: status, alloc_page, largest_free
// cfg      in   cfg_valid, cfg_ready   base_page, 20 bits
//
// alloc of a block at tree depth d: one tree level a cycle down to depth d
// and back up to the root on the single read port of the tree memory
// free: climbs from the page's leaf to the used node, then merges up to the root
// a rejected request goes from the check straight to done
// a new word is taken in the done cycle; results cannot be stalled
// after reset a clearing pass over every tree node holds busy high
module buddy_page_allocator_core #(
	parameter int PAGES = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  bpa_pkg::bpa_in_t            item,
	output logic                        done,
	output bpa_pkg::bpa_out_t           result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bpa_pkg::PAGE_W-1:0]  cfg_data
);

	bpa_pkg::bpa_cmd_t cmd;
	bpa_pkg::bpa_sts_t sts;

	// base register always writable
	assign cfg_ready = 1'b1;

	bpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.sts    (sts),
		.cmd    (cmd)
	);

	bpa_dpath #(
		.PAGES (PAGES)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.item     (item),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.result   (result)
	);

endmodule

@@ design/bpa_ctrl.sv @@
// controller state machine for the buddy page allocator
// depends on bpa_pkg; drives bpa_dpath through command and status structs
module bpa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	input  bpa_pkg::bpa_sts_t  sts,
	output bpa_pkg::bpa_cmd_t  cmd
);

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_CHK   = 8'b0000_0100,
		S_DESC  = 8'b0000_1000,
		S_MARK  = 8'b0001_0000,
		S_CLIMB = 8'b0010_0000,
		S_UP    = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	// handshake outputs
	assign busy = !((state_q == S_IDLE) || (state_q == S_DONE));
	assign done = (state_q == S_DONE);

	// next state and datapath command
	always_comb begin
		state_d     = state_q;
		cmd.op      = bpa_pkg::DP_NOP;
		cmd.st_we   = 1'b0;
		cmd.st_code = bpa_pkg::ST_OK;
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = bpa_pkg::DP_CLR;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE, S_DONE: begin
				state_d = S_IDLE;
				if (start) begin
					cmd.op  = bpa_pkg::DP_LOAD;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (!sts.op_free) begin
					if (sts.no_space) begin
						cmd.st_we   = 1'b1;
						cmd.st_code = bpa_pkg::ST_NO_SPACE;
						state_d     = S_DONE;
					end else begin
						cmd.op  = bpa_pkg::DP_DINIT;
						state_d = sts.root_gt_need ? S_DESC : S_MARK;
					end
				end else if (sts.out_range) begin
					cmd.st_we   = 1'b1;
					cmd.st_code = bpa_pkg::ST_NOT_ALLOCATED;
					state_d     = S_DONE;
				end else begin
					cmd.op  = bpa_pkg::DP_LINIT;
					state_d = S_CLIMB;
				end
			end
			S_DESC: begin
				cmd.op  = bpa_pkg::DP_DSTEP;
				state_d = sts.half_gt_need ? S_DESC : S_MARK;
			end
			S_MARK: begin
				cmd.op  = bpa_pkg::DP_MARK;
				state_d = sts.at_root ? S_DONE : S_UP;
			end
			S_CLIMB: begin
				priority if (sts.node_used) begin
					cmd.op  = bpa_pkg::DP_RESTORE;
					state_d = sts.at_root ? S_DONE : S_UP;
				end else if (sts.at_root) begin
					cmd.st_we   = 1'b1;
					cmd.st_code = bpa_pkg::ST_NOT_ALLOCATED;
					state_d     = S_DONE;
				end else begin
					cmd.op = bpa_pkg::DP_CLIMB;
				end
			end
			S_UP: begin
				cmd.op  = bpa_pkg::DP_MERGE;
				state_d = sts.parent_root ? S_DONE : S_UP;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register, clearing pass first after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ design/bpa_dpath.sv @@
// datapath of the buddy page allocator: tree memory, walk registers, result
// depends on bpa_pkg; acts on commands from bpa_ctrl
module bpa_dpath #(
	parameter int PAGES = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bpa_pkg::bpa_cmd_t             cmd,
	output bpa_pkg::bpa_sts_t             sts,
	input  bpa_pkg::bpa_in_t              item,
	input  logic                          cfg_we,
	input  logic [bpa_pkg::PAGE_W-1:0]    cfg_data,
	output bpa_pkg::bpa_out_t             result
);

	localparam int LW    = $clog2(PAGES);
	localparam int IW    = LW + 1;
	localparam int VW    = LW + 1;
	localparam int NODES = 2 * PAGES - 1;
	localparam int CW    = (VW > bpa_pkg::NEED_W) ? VW : bpa_pkg::NEED_W;

	typedef logic [IW-1:0] idx_t;
	typedef logic [IW:0]   idx_x_t;
	typedef logic [VW-1:0] val_t;
	typedef logic [VW:0]   sum_t;
	typedef logic [LW-1:0] off_t;
	typedef logic [CW-1:0] cmp_t;

	// request rounded up to a power of two, zero taken as one
	function automatic bpa_pkg::need_t round_pow2(input bpa_pkg::req_t r);
		bpa_pkg::req_t m;
		m = (r == '0) ? '0 : r - bpa_pkg::req_t'(1);
		m = m | (m >> 1);
		m = m | (m >> 2);
		m = m | (m >> 4);
		m = m | (m >> 8);
		return bpa_pkg::need_t'(m) + bpa_pkg::need_t'(1);
	endfunction

	// tree of longest free block per node
	val_t tree_mem [NODES];
	val_t rd_q;

	idx_t            idx_q;
	val_t            size_q;
	val_t            root_q;
	bpa_pkg::page_t  base_q;
	off_t            off_q;
	val_t            cur_q;
	bpa_pkg::need_t  need_q;
	logic            op_q;
	bpa_pkg::page_t  fpage_q;
	bpa_pkg::page_t  page_q;
	bpa_pkg::st_t    st_q;

	idx_t            left_c;
	idx_t            next_c;
	idx_t            parent_c;
	idx_t            sib_c;
	idx_t            sib_par_c;
	idx_t            leaf_c;
	logic            go_left;
	val_t            half_c;
	val_t            psize_c;
	bpa_pkg::page_t  diff_c;
	sum_t            sum_c;
	val_t            max_c;
	val_t            merge_c;
	idx_x_t          clr_nx;
	logic            clr_lvl;
	idx_t            ra;
	idx_t            wa;
	val_t            wd;
	logic            we;

	// tree index arithmetic
	assign left_c    = {idx_q[IW-2:0], 1'b1};
	assign go_left   = cmp_t'(rd_q) >= cmp_t'(need_q);
	assign next_c    = go_left ? left_c : left_c + idx_t'(1);
	assign parent_c  = idx_t'((idx_q - idx_t'(1)) >> 1);
	assign sib_c     = idx_q[0] ? idx_q + idx_t'(1) : idx_q - idx_t'(1);
	assign sib_par_c = parent_c[0] ? parent_c + idx_t'(1) : parent_c - idx_t'(1);
	assign half_c    = size_q >> 1;
	assign psize_c   = size_q << 1;

	// free page to leaf
	assign diff_c = fpage_q - base_q;
	assign leaf_c = idx_t'(diff_c[LW-1:0]) + idx_t'(PAGES - 1);

	// parent value from the walked child and its sibling
	assign sum_c   = sum_t'(cur_q) + sum_t'(rd_q);
	assign max_c   = (cur_q > rd_q) ? cur_q : rd_q;
	assign merge_c = ((op_q == bpa_pkg::OP_FREE) && (sum_c == sum_t'(psize_c))) ?
		psize_c : max_c;

	// clearing pass: size halves at the first node of each level
	assign clr_nx  = idx_x_t'(idx_q) + idx_x_t'(1);
	assign clr_lvl = ((clr_nx + idx_x_t'(1)) & clr_nx) == '0;

	// memory address and write selection
	always_comb begin
		ra = idx_q;
		wa = idx_q;
		wd = size_q;
		we = 1'b0;
		unique case (cmd.op)
			bpa_pkg::DP_CLR: begin
				we = 1'b1;
			end
			bpa_pkg::DP_DINIT: begin
				ra = idx_t'(1);
			end
			bpa_pkg::DP_DSTEP: begin
				ra = {next_c[IW-2:0], 1'b1};
			end
			bpa_pkg::DP_MARK: begin
				we = 1'b1;
				wd = '0;
				ra = sib_c;
			end
			bpa_pkg::DP_LINIT: begin
				ra = leaf_c;
			end
			bpa_pkg::DP_CLIMB: begin
				ra = parent_c;
			end
			bpa_pkg::DP_RESTORE: begin
				we = 1'b1;
				ra = sib_c;
			end
			bpa_pkg::DP_MERGE: begin
				we = 1'b1;
				wa = parent_c;
				wd = merge_c;
				ra = sib_par_c;
			end
			default: begin
				ra = idx_q;
			end
		endcase
	end

	// tree memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			tree_mem[wa] <= wd;
		end
		rd_q <= tree_mem[ra];
	end

	// walk position, root copy and base register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			size_q <= val_t'(PAGES);
			root_q <= val_t'(PAGES);
			base_q <= '0;
		end else begin
			if (cfg_we) begin
				base_q <= cfg_data;
			end
			if (we && (wa == '0)) begin
				root_q <= wd;
			end
			unique case (cmd.op)
				bpa_pkg::DP_CLR: begin
					idx_q <= clr_nx[IW-1:0];
					if (clr_lvl) begin
						size_q <= half_c;
					end
				end
				bpa_pkg::DP_DINIT: begin
					idx_q  <= '0;
					size_q <= val_t'(PAGES);
				end
				bpa_pkg::DP_DSTEP: begin
					idx_q  <= next_c;
					size_q <= half_c;
				end
				bpa_pkg::DP_LINIT: begin
					idx_q  <= leaf_c;
					size_q <= val_t'(1);
				end
				bpa_pkg::DP_CLIMB, bpa_pkg::DP_MERGE: begin
					idx_q  <= parent_c;
					size_q <= psize_c;
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

	// request, offset, running node value and result fields
	always_ff @(posedge clk) begin
		if (cmd.st_we) begin
			st_q <= cmd.st_code;
		end
		unique case (cmd.op)
			bpa_pkg::DP_LOAD: begin
				op_q    <= item.op;
				need_q  <= round_pow2(item.request_pages);
				fpage_q <= item.free_page;
				st_q    <= bpa_pkg::ST_OK;
				page_q  <= '0;
			end
			bpa_pkg::DP_DINIT: begin
				off_q <= '0;
			end
			bpa_pkg::DP_DSTEP: begin
				if (!go_left) begin
					off_q <= off_q + off_t'(half_c);
				end
			end
			bpa_pkg::DP_MARK: begin
				cur_q  <= '0;
				page_q <= base_q + bpa_pkg::page_t'(off_q);
			end
			bpa_pkg::DP_RESTORE: begin
				cur_q <= size_q;
			end
			bpa_pkg::DP_MERGE: begin
				cur_q <= merge_c;
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

	// status to the controller
	assign sts.clr_last     = (idx_q == idx_t'(NODES - 1));
	assign sts.op_free      = (op_q == bpa_pkg::OP_FREE);
	assign sts.no_space     = cmp_t'(need_q) > cmp_t'(root_q);
	assign sts.root_gt_need = cmp_t'(PAGES) > cmp_t'(need_q);
	assign sts.half_gt_need = cmp_t'(half_c) > cmp_t'(need_q);
	assign sts.out_range    = diff_c >= bpa_pkg::page_t'(PAGES);
	assign sts.at_root      = (idx_q == '0);
	assign sts.parent_root  = (parent_c == '0);
	assign sts.node_used    = (rd_q == '0);

	// result word
	assign result.status       = st_q;
	assign result.alloc_page   = page_q;
	assign result.largest_free = bpa_pkg::lf_t'(root_q);

endmodule

@@ design/bpa_chk.sv @@
// port checker for the buddy page allocator, bound to the top level
// depends on bpa_pkg and buddy_page_allocator_core_defines.svh
`include "buddy_page_allocator_core_defines.svh"

module bpa_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input bpa_pkg::bpa_out_t result
);

	// result strobe only while ready for the next word
	`BPA_ASSERT_SAME(a_done_not_busy, clk, arst_n, done, !busy, "done while busy")

	// an accepted word keeps the block busy next cycle
	`BPA_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accept without busy")

	// strobe lasts a single cycle
	`BPA_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done, "done held two cycles")

	// failed operations carry no page
	`BPA_ASSERT_SAME(a_fail_no_page, clk, arst_n, done && (result.status != bpa_pkg::ST_OK), result.alloc_page == '0, "page on failed op")

	// status is one of the defined codes
	`BPA_ASSERT_SAME(a_status_code, clk, arst_n, done, (result.status == bpa_pkg::ST_OK) || (result.status == bpa_pkg::ST_NO_SPACE) || (result.status == bpa_pkg::ST_NOT_ALLOCATED), "bad status code")

endmodule

bind buddy_page_allocator_core bpa_chk u_bpa_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
